// File: rtl/hcs_pkg.sv
// Package with the constants, codes, state and command types of the heap census unit.
`timescale 1ns / 1ps
`default_nettype none
package hcs_pkg;
    localparam int NUM_TYPES_DEF     = 32;
    localparam int LIVE_LOG_DEF      = 4096;
    localparam int SMALL_BUCKETS     = 128;
    localparam int NUM_BUCKETS       = SMALL_BUCKETS + 11;
    localparam int NUM_AGES          = 5;
    localparam int NUM_RAW           = 6;
    localparam int BUCKET_W          = 8;

    localparam logic [2:0] CMD_BIRTH    = 3'd0;
    localparam logic [2:0] CMD_DEATH    = 3'd1;
    localparam logic [2:0] CMD_RAW      = 3'd2;
    localparam logic [2:0] CMD_GC_END   = 3'd3;
    localparam logic [2:0] CMD_TEARDOWN = 3'd4;
    localparam logic [2:0] CMD_READ     = 3'd5;

    localparam logic [3:0] RK_COUNT     = 4'd0;
    localparam logic [3:0] RK_BYTES     = 4'd1;
    localparam logic [3:0] RK_HIST      = 4'd2;
    localparam logic [3:0] RK_AGE       = 4'd3;
    localparam logic [3:0] RK_TEARDOWN  = 4'd4;
    localparam logic [3:0] RK_RAW_CTR   = 4'd5;
    localparam logic [3:0] RK_RAW_HIST  = 4'd6;
    localparam logic [3:0] RK_PEAK_B    = 4'd7;
    localparam logic [3:0] RK_PEAK_O    = 4'd8;
    localparam logic [3:0] RK_LAST_B    = 4'd9;
    localparam logic [3:0] RK_LAST_O    = 4'd10;
    localparam logic [3:0] RK_EPOCH     = 4'd11;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic fetch;
        logic update;
        logic out_load;
    } hcs_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic has_result;
    } hcs_status_t;

    function automatic logic [BUCKET_W-1:0] size_bucket(input logic [39:0] size);
        logic [BUCKET_W-1:0] b;
        b = BUCKET_W'(SMALL_BUCKETS);
        if (size < 40'd1024) begin
            b = BUCKET_W'(size[9:3]);
        end else begin
            for (int i = 1; i <= 10; i++) begin
                if ((size >> (10 + i)) != 40'd0) b = BUCKET_W'(SMALL_BUCKETS + i);
            end
        end
        return b;
    endfunction
endpackage
`default_nettype wire

// File: rtl/heap_census_statistics_unit_top.sv
// Top level of the heap census statistics unit.
// Usage: one event word enters on the s_ channel (valid/ready); a read
// command (cmd 5) returns one word on m_stat_value over the m_ channel,
// other commands return nothing.
// Each event passes through the controller states accept, memory fetch,
// then update; a read adds an output state that loads the output register
// and raises m_valid once no earlier result is still waiting.
// A new event is accepted only after the previous one is finished, set by
// the read-modify-write of the single-port per-type histogram memory.
// After reset the block sweeps the histogram and counter memories with
// s_ready low; all counters read zero.
// When the receiver stalls, a read result waits in the output register;
// the next event may still be accepted and run, but a following read
// holds in its final state until the earlier result is taken.
`timescale 1ns / 1ps
`default_nettype none
module heap_census_statistics_unit_top #(
    parameter int NUM_TYPES = hcs_pkg::NUM_TYPES_DEF,
    parameter int LIVE_LOG  = hcs_pkg::LIVE_LOG_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_cmd,
    input  wire logic signed [7:0] s_obj_type,
    input  wire logic [39:0]       s_obj_size,
    input  wire logic [31:0]       s_birth_epoch,
    input  wire logic [39:0]       s_old_size,
    input  wire logic [39:0]       s_new_size,
    input  wire logic [39:0]       s_live_bytes,
    input  wire logic [63:0]       s_live_objects,
    input  wire logic [3:0]        s_read_kind,
    input  wire logic [4:0]        s_read_row,
    input  wire logic [7:0]        s_read_col,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [63:0]            m_stat_value
);
    import hcs_pkg::*;

    hcs_cmd_t    cmd;
    hcs_status_t status;

    hcs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .status(status), .cmd(cmd)
    );

    hcs_datapath #(.NUM_TYPES(NUM_TYPES), .LIVE_LOG(LIVE_LOG)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .s_cmd(s_cmd), .s_obj_type(s_obj_type), .s_obj_size(s_obj_size),
        .s_birth_epoch(s_birth_epoch), .s_old_size(s_old_size),
        .s_new_size(s_new_size), .s_live_bytes(s_live_bytes),
        .s_live_objects(s_live_objects), .s_read_kind(s_read_kind),
        .s_read_row(s_read_row), .s_read_col(s_read_col),
        .m_stat_value(m_stat_value)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_ready) else $error("input accepted during clear sweep");
    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.fetch) else $error("accepted word not fetched");
    a_out_only_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.is_read) else $error("result for non-read command");
`endif
endmodule
`default_nettype wire

// File: rtl/hcs_ctrl.sv
// Controller state machine sequencing the clear pass and each event of the heap census unit.
`timescale 1ns / 1ps
`default_nettype none
module hcs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire hcs_pkg::hcs_status_t status,
    output hcs_pkg::hcs_cmd_t        cmd
);
    import hcs_pkg::*;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.has_result ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!mv_next) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/hcs_datapath.sv
// Datapath holding the counter memories and registers and doing the read-modify-write.
`timescale 1ns / 1ps
`default_nettype none
module hcs_datapath #(
    parameter int NUM_TYPES = hcs_pkg::NUM_TYPES_DEF,
    parameter int LIVE_LOG  = hcs_pkg::LIVE_LOG_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hcs_pkg::hcs_cmd_t    cmd,
    output hcs_pkg::hcs_status_t      status,
    input  wire logic [2:0]           s_cmd,
    input  wire logic signed [7:0]    s_obj_type,
    input  wire logic [39:0]          s_obj_size,
    input  wire logic [31:0]          s_birth_epoch,
    input  wire logic [39:0]          s_old_size,
    input  wire logic [39:0]          s_new_size,
    input  wire logic [39:0]          s_live_bytes,
    input  wire logic [63:0]          s_live_objects,
    input  wire logic [3:0]           s_read_kind,
    input  wire logic [4:0]           s_read_row,
    input  wire logic [7:0]           s_read_col,
    output logic [63:0]               m_stat_value
);
    import hcs_pkg::*;

    localparam int TW      = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int HDEPTH  = NUM_TYPES * NUM_BUCKETS;
    localparam int HW      = $clog2(HDEPTH);
    localparam int ADEPTH  = NUM_TYPES * NUM_AGES;
    localparam int AW      = $clog2(ADEPTH);
    localparam int CW      = HW + 1;

    logic [63:0] hist_mem [HDEPTH];
    logic [63:0] age_mem  [ADEPTH];
    logic [63:0] cnt_mem  [NUM_TYPES];
    logic [63:0] byt_mem  [NUM_TYPES];
    logic [63:0] td_mem   [NUM_TYPES];
    logic [63:0] rhist_mem[NUM_BUCKETS];
    logic [63:0] raw_reg  [NUM_RAW];

    logic [CW-1:0] clr_reg;
    logic [31:0]   epoch_reg;
    logic          td_reg;
    logic [63:0]   peak_b_reg, peak_o_reg, last_b_reg, last_o_reg;

    logic [2:0]    op_reg;
    logic [TW-1:0] t_reg;
    logic [39:0]   size_reg, old_reg, new_reg, lb_reg;
    logic [63:0]   lo_reg;
    logic [31:0]   be_reg;
    logic [3:0]    rk_reg;
    logic [4:0]    rr_reg;
    logic [7:0]    rc_reg;
    logic [BUCKET_W-1:0] bk_reg;

    logic [63:0] h_rd_reg, a_rd_reg, c_rd_reg, b_rd_reg, td_rd_reg, rh_rd_reg;
    logic [63:0] rd_val_reg, out_reg;

    logic [TW-1:0] t_map;
    logic [31:0]   age;
    logic [2:0]    slot;
    logic [HW-1:0] h_addr;
    logic [AW-1:0] a_addr;
    logic [BUCKET_W-1:0] bk_in;
    logic          row_ok;
    logic [63:0]   rd_val;

    always_comb begin
        if (s_obj_type[7] || (int'(s_obj_type[6:0]) >= NUM_TYPES))
            t_map = TW'(NUM_TYPES - 1);
        else
            t_map = TW'(s_obj_type[6:0]);
        bk_in = (s_cmd == CMD_RAW) ? size_bucket(s_new_size) : size_bucket(s_obj_size);
    end

    always_comb begin
        age = epoch_reg - be_reg;
        if (age == 32'd0)      slot = 3'd0;
        else if (age == 32'd1) slot = 3'd1;
        else if (age == 32'd2) slot = 3'd2;
        else if (age < 32'd8)  slot = 3'd3;
        else                   slot = 3'd4;
    end

    always_comb begin
        if (op_reg == CMD_READ) begin
            h_addr = HW'(rr_reg * NUM_BUCKETS + rc_reg);
            a_addr = AW'(rr_reg * NUM_AGES + rc_reg[2:0]);
        end else begin
            h_addr = HW'(t_reg * NUM_BUCKETS + bk_reg);
            a_addr = AW'(t_reg * NUM_AGES + slot);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_cmd;
            t_reg    <= t_map;
            size_reg <= s_obj_size;
            old_reg  <= s_old_size;
            new_reg  <= s_new_size;
            lb_reg   <= s_live_bytes;
            lo_reg   <= s_live_objects;
            be_reg   <= s_birth_epoch;
            rk_reg   <= s_read_kind;
            rr_reg   <= s_read_row;
            rc_reg   <= s_read_col;
            bk_reg   <= bk_in;
        end
    end

    // Registered reads for both update and read commands.
    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            h_rd_reg  <= hist_mem[h_addr];
            a_rd_reg  <= age_mem[a_addr];
            c_rd_reg  <= cnt_mem[(op_reg == CMD_READ) ? TW'(rr_reg) : t_reg];
            b_rd_reg  <= byt_mem[(op_reg == CMD_READ) ? TW'(rr_reg) : t_reg];
            td_rd_reg <= td_mem[(op_reg == CMD_READ) ? TW'(rr_reg) : t_reg];
            rh_rd_reg <= rhist_mem[(op_reg == CMD_READ) ? rc_reg : bk_reg];
        end
    end

    assign row_ok = {3'b0, rr_reg} < 8'(NUM_TYPES) || NUM_TYPES > 31;

    always_comb begin
        case (rk_reg)
            RK_COUNT:    rd_val = row_ok ? c_rd_reg : '0;
            RK_BYTES:    rd_val = row_ok ? b_rd_reg : '0;
            RK_HIST:     rd_val = (row_ok && rc_reg < 8'(NUM_BUCKETS)) ? h_rd_reg : '0;
            RK_AGE:      rd_val = (row_ok && rc_reg < 8'(NUM_AGES)) ? a_rd_reg : '0;
            RK_TEARDOWN: rd_val = row_ok ? td_rd_reg : '0;
            RK_RAW_CTR:  rd_val = (rc_reg < 8'(NUM_RAW)) ? raw_reg[rc_reg[2:0]] : '0;
            RK_RAW_HIST: rd_val = (rc_reg < 8'(NUM_BUCKETS)) ? rh_rd_reg : '0;
            RK_PEAK_B:   rd_val = peak_b_reg;
            RK_PEAK_O:   rd_val = peak_o_reg;
            RK_LAST_B:   rd_val = last_b_reg;
            RK_LAST_O:   rd_val = last_o_reg;
            RK_EPOCH:    rd_val = {32'd0, epoch_reg};
            default:     rd_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) rd_val_reg <= rd_val;
        if (cmd.out_load) out_reg <= rd_val_reg;
    end
    assign m_stat_value = out_reg;

    // Memory writes: clearing sweep after reset, otherwise at most one update per event.
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            if (clr_reg < CW'(HDEPTH)) hist_mem[clr_reg[HW-1:0]] <= '0;
            if (clr_reg < CW'(ADEPTH)) age_mem[clr_reg[AW-1:0]] <= '0;
            if (clr_reg < CW'(NUM_TYPES)) begin
                cnt_mem[clr_reg[TW-1:0]] <= '0;
                byt_mem[clr_reg[TW-1:0]] <= '0;
                td_mem[clr_reg[TW-1:0]]  <= '0;
            end
            if (clr_reg < CW'(NUM_BUCKETS)) rhist_mem[clr_reg[BUCKET_W-1:0]] <= '0;
        end else if (cmd.update) begin
            case (op_reg)
                CMD_BIRTH: begin
                    cnt_mem[t_reg]  <= c_rd_reg + 64'd1;
                    byt_mem[t_reg]  <= b_rd_reg + {24'd0, size_reg};
                    hist_mem[h_addr] <= h_rd_reg + 64'd1;
                end
                CMD_DEATH: begin
                    if (td_reg) td_mem[t_reg] <= td_rd_reg + 64'd1;
                    else        age_mem[a_addr] <= a_rd_reg + 64'd1;
                end
                CMD_RAW: begin
                    if (old_reg == '0 && new_reg != '0)
                        rhist_mem[bk_reg] <= rh_rd_reg + 64'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg    <= '0;
            epoch_reg  <= '0;
            td_reg     <= 1'b0;
            peak_b_reg <= '0;
            peak_o_reg <= '0;
            last_b_reg <= '0;
            last_o_reg <= '0;
            for (int i = 0; i < NUM_RAW; i++) raw_reg[i] <= '0;
        end else begin
            if (cmd.clear) clr_reg <= clr_reg + CW'(1);
            if (cmd.update) begin
                case (op_reg)
                    CMD_RAW: begin
                        if (old_reg == '0 && new_reg != '0) begin
                            raw_reg[0] <= raw_reg[0] + 64'd1;
                            raw_reg[1] <= raw_reg[1] + {24'd0, new_reg};
                        end else if (new_reg == '0 && old_reg != '0) begin
                            raw_reg[5] <= raw_reg[5] + 64'd1;
                        end else if (new_reg > old_reg) begin
                            raw_reg[2] <= raw_reg[2] + 64'd1;
                            raw_reg[3] <= raw_reg[3] + {24'd0, new_reg - old_reg};
                        end else if (new_reg < old_reg) begin
                            raw_reg[4] <= raw_reg[4] + 64'd1;
                        end
                    end
                    CMD_GC_END: begin
                        if ({1'b0, epoch_reg} < 33'(LIVE_LOG)) begin
                            last_b_reg <= {24'd0, lb_reg};
                            last_o_reg <= lo_reg;
                            if ({24'd0, lb_reg} > peak_b_reg) peak_b_reg <= {24'd0, lb_reg};
                            if (lo_reg > peak_o_reg) peak_o_reg <= lo_reg;
                        end
                        epoch_reg <= epoch_reg + 32'd1;
                    end
                    CMD_TEARDOWN: td_reg <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign status.clear_done = (clr_reg == CW'(HDEPTH - 1));
    assign status.is_read    = (op_reg == CMD_READ);
    assign status.has_result = (op_reg == CMD_READ);
endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the heap census statistics unit, with its own predictor.
`timescale 1ns / 1ps
module tb_top;
    import hcs_pkg::*;

    localparam int NT = 32;
    localparam int LOGN = 4096;
    localparam longint CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_cmd = '0;
    logic signed [7:0] s_obj_type = '0;
    logic [39:0] s_obj_size = '0;
    logic [31:0] s_birth_epoch = '0;
    logic [39:0] s_old_size = '0;
    logic [39:0] s_new_size = '0;
    logic [39:0] s_live_bytes = '0;
    logic [63:0] s_live_objects = '0;
    logic [3:0] s_read_kind = '0;
    logic [4:0] s_read_row = '0;
    logic [7:0] s_read_col = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_stat_value;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] otype;
        logic [39:0] osize;
        logic [31:0] bepoch;
        logic [39:0] old_sz;
        logic [39:0] new_sz;
        logic [39:0] lbytes;
        logic [63:0] lobjs;
        logic [3:0] kind;
        logic [4:0] row;
        logic [7:0] col;
    } event_t;

    logic [63:0] cnt_by_type [NT];
    logic [63:0] bytes_by_type [NT];
    logic [63:0] size_hist [NT][NUM_BUCKETS];
    logic [63:0] age_hist [NT][NUM_AGES];
    logic [63:0] teardown_cnt [NT];
    logic [63:0] raw_ctr [NUM_RAW];
    logic [63:0] raw_hist [NUM_BUCKETS];
    logic [31:0] cur_epoch;
    logic teardown_on;
    logic [63:0] peak_b, peak_o, last_b, last_o;

    logic [63:0] pending_stats [$];
    int errors = 0;
    longint cycles = 0;

    heap_census_statistics_unit_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int bucket_of(logic [39:0] size);
        int b;
        logic [39:0] lim;
        if (size < 40'd1024) return int'(size >> 3);
        b = SMALL_BUCKETS;
        lim = 40'd1024;
        while (b < NUM_BUCKETS - 1 && size >= (lim << 1)) begin
            lim = lim << 1;
            b++;
        end
        return b;
    endfunction

    task automatic clear_census();
        for (int t = 0; t < NT; t++) begin
            cnt_by_type[t] = 0;
            bytes_by_type[t] = 0;
            teardown_cnt[t] = 0;
            for (int b = 0; b < NUM_BUCKETS; b++) size_hist[t][b] = 0;
            for (int a = 0; a < NUM_AGES; a++) age_hist[t][a] = 0;
        end
        for (int r = 0; r < NUM_RAW; r++) raw_ctr[r] = 0;
        for (int b = 0; b < NUM_BUCKETS; b++) raw_hist[b] = 0;
        cur_epoch = 0;
        teardown_on = 0;
        peak_b = 0;
        peak_o = 0;
        last_b = 0;
        last_o = 0;
    endtask

    task automatic apply_event(event_t e);
        int t;
        int b;
        logic [31:0] age;
        logic [63:0] v;
        t = (e.otype[7] || e.otype >= NT) ? NT - 1 : int'(e.otype);
        case (e.cmd)
            CMD_BIRTH: begin
                cnt_by_type[t]++;
                bytes_by_type[t] += 64'(e.osize);
                b = bucket_of(e.osize);
                size_hist[t][b]++;
            end
            CMD_DEATH: begin
                if (teardown_on) begin
                    teardown_cnt[t]++;
                end else begin
                    age = cur_epoch - e.bepoch;
                    b = age == 0 ? 0 : age == 1 ? 1 : age == 2 ? 2 : age < 8 ? 3 : 4;
                    age_hist[t][b]++;
                end
            end
            CMD_RAW: begin
                if (e.old_sz == 0 && e.new_sz > 0) begin
                    raw_ctr[0]++;
                    raw_ctr[1] += 64'(e.new_sz);
                    b = bucket_of(e.new_sz);
                    raw_hist[b]++;
                end else if (e.new_sz == 0 && e.old_sz > 0) begin
                    raw_ctr[5]++;
                end else if (e.new_sz > e.old_sz) begin
                    raw_ctr[2]++;
                    raw_ctr[3] += 64'(e.new_sz - e.old_sz);
                end else if (e.new_sz < e.old_sz) begin
                    raw_ctr[4]++;
                end
            end
            CMD_GC_END: begin
                if (cur_epoch < LOGN) begin
                    last_b = 64'(e.lbytes);
                    last_o = e.lobjs;
                    if (64'(e.lbytes) > peak_b) peak_b = 64'(e.lbytes);
                    if (e.lobjs > peak_o) peak_o = e.lobjs;
                end
                cur_epoch++;
            end
            CMD_TEARDOWN: teardown_on = 1;
            CMD_READ: begin
                v = 0;
                case (e.kind)
                    RK_COUNT: if (e.row < NT) v = cnt_by_type[e.row];
                    RK_BYTES: if (e.row < NT) v = bytes_by_type[e.row];
                    RK_HIST: if (e.row < NT && e.col < NUM_BUCKETS) v = size_hist[e.row][e.col];
                    RK_AGE: if (e.row < NT && e.col < NUM_AGES) v = age_hist[e.row][e.col];
                    RK_TEARDOWN: if (e.row < NT) v = teardown_cnt[e.row];
                    RK_RAW_CTR: if (e.col < NUM_RAW) v = raw_ctr[e.col];
                    RK_RAW_HIST: if (e.col < NUM_BUCKETS) v = raw_hist[e.col];
                    RK_PEAK_B: v = peak_b;
                    RK_PEAK_O: v = peak_o;
                    RK_LAST_B: v = last_b;
                    RK_LAST_O: v = last_o;
                    RK_EPOCH: v = 64'(cur_epoch);
                    default: v = 0;
                endcase
                pending_stats.push_back(v);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic send_word(event_t e);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= e.cmd;
        s_obj_type <= e.otype;
        s_obj_size <= e.osize;
        s_birth_epoch <= e.bepoch;
        s_old_size <= e.old_sz;
        s_new_size <= e.new_sz;
        s_live_bytes <= e.lbytes;
        s_live_objects <= e.lobjs;
        s_read_kind <= e.kind;
        s_read_row <= e.row;
        s_read_col <= e.col;
        do @(posedge aclk); while (!s_ready);
        apply_event(e);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_stats.size() == 0) begin
                report_mismatch("unexpected word", m_stat_value, '0);
            end else begin
                if (m_stat_value !== pending_stats[0])
                    report_mismatch("stat_value", m_stat_value, pending_stats[0]);
                void'(pending_stats.pop_front());
            end
        end
    end

    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            stall = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 11));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic logic [39:0] rand40();
        case ($urandom_range(0, 5))
            0: return 40'($urandom_range(0, 1023));
            1: return 40'($urandom_range(1024, 1 << 21));
            2: return {8'($urandom), 32'($urandom)};
            3: return 40'(1) << $urandom_range(0, 39);
            4: return '1;
            default: return 40'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic event_t random_event(logic [2:0] cmd);
        event_t e;
        e.cmd = cmd;
        e.otype = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, NT - 1));
        e.osize = rand40();
        e.bepoch = $urandom_range(0, 1) ? cur_epoch - 32'($urandom_range(0, 10)) : $urandom;
        e.old_sz = rand40();
        e.new_sz = $urandom_range(0, 5) == 0 ? e.old_sz : rand40();
        e.lbytes = rand40();
        e.lobjs = {$urandom, $urandom};
        e.kind = $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 11));
        e.row = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 3));
        e.col = 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 138));
        return e;
    endfunction

    task automatic send_read(logic [3:0] kind, logic [4:0] row, logic [7:0] col);
        event_t e;
        e = random_event(CMD_READ);
        e.kind = kind;
        e.row = row;
        e.col = col;
        send_word(e);
    endtask

    task automatic test_directed();
        event_t e;
        e = random_event(CMD_BIRTH); e.otype = 8'h80; e.osize = '1; send_word(e);
        e = random_event(CMD_BIRTH); e.otype = 8'd0; e.osize = 40'd1023; send_word(e);
        e = random_event(CMD_BIRTH); e.otype = 8'd1; e.osize = 40'd1024; send_word(e);
        e = random_event(CMD_RAW); e.old_sz = 0; e.new_sz = 0; send_word(e);
        e = random_event(CMD_RAW); e.old_sz = 0; e.new_sz = '1; send_word(e);
        e = random_event(CMD_RAW); e.old_sz = 5; e.new_sz = 0; send_word(e);
        e = random_event(CMD_RAW); e.old_sz = 5; e.new_sz = 9; send_word(e);
        e = random_event(CMD_RAW); e.old_sz = 9; e.new_sz = 5; send_word(e);
        e = random_event(CMD_DEATH); e.otype = 8'd2; e.bepoch = 32'd1; send_word(e);
        e = random_event(CMD_GC_END); e.lbytes = '1; e.lobjs = '1; send_word(e);
        e = random_event(3'd6); send_word(e);
        e = random_event(3'd7); send_word(e);
        for (int k = 0; k < 16; k++) send_read(4'(k), 5'(k), 8'(k * 17));
        send_read(RK_HIST, 5'd31, 8'd138);
        send_read(RK_HIST, 5'd0, 8'd127);
        send_read(RK_AGE, 5'd2, 8'd4);
        send_read(RK_RAW_HIST, 5'd0, 8'd138);
    endtask

    task automatic test_random_traffic(int n);
        event_t e;
        logic [2:0] c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 9) < 4 ? CMD_READ : 3'($urandom_range(0, 3));
            if ($urandom_range(0, 99) == 0) c = 3'($urandom);
            e = random_event(c);
            send_word(e);
        end
    endtask

    task automatic test_drain_pause();
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic test_gc_epochs();
        event_t e;
        for (int k = 0; k < 40; k++) begin
            e = random_event(CMD_GC_END);
            if (k % 4 == 0) e.lbytes = '0;
            send_word(e);
        end
        for (int k = 7; k <= 11; k++) send_read(4'(k), '0, '0);
    endtask

    task automatic test_teardown();
        event_t e;
        e = random_event(CMD_TEARDOWN);
        send_word(e);
        test_random_traffic(300);
        for (int r = 0; r < NT; r++) send_read(RK_TEARDOWN, 5'(r), '0);
    endtask

    initial begin
        int wait_cycles;
        clear_census();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_traffic(900);
        test_drain_pause();
        test_gc_epochs();
        test_random_traffic(300);
        test_teardown();
        s_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_stats.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (30) @(posedge aclk);
        if (errors == 0 && pending_stats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
